[src/hmtc_pkg.sv]
package hmtc_pkg;

  localparam int MaxDeltaBytes = 4;
  localparam int DCntW = (MaxDeltaBytes > 1) ? $clog2(MaxDeltaBytes) : 1;
  localparam int NumW = $clog2(MaxDeltaBytes + 1);
  localparam int GrpDepth = (MaxDeltaBytes > 1) ? MaxDeltaBytes - 1 : 1;

  localparam logic [7:0] MetaByte = 8'hFF;
  localparam logic [7:0] EndOfTrack = 8'h2F;
  localparam logic [3:0] HiProgChange = 4'hC;
  localparam logic [3:0] HiChanPress = 4'hD;
  localparam logic [3:0] HiSystem = 4'hF;

  typedef enum logic [5:0] {
    PhDelta    = 6'b000001,
    PhEvent    = 6'b000010,
    PhMetaType = 6'b000100,
    PhMetaLen  = 6'b001000,
    PhMetaBody = 6'b010000,
    PhChan     = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StEnd       = 3'd1,
    StBadStatus = 3'd2,
    StDeltaLong = 3'd3,
    StSystem    = 3'd4,
    StTrunc     = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [NumW-1:0]                num;
    logic [MaxDeltaBytes-1:0][7:0] data;
    status_e                        code;
  } result_t;

endpackage

[src/hmtc_parser.sv]
module hmtc_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  hmtc_pkg::beat_t  beat_i,
  output hmtc_pkg::result_t res_o
);
  import hmtc_pkg::*;

  phase_e           phase_q, phase_d;
  logic [DCntW-1:0] cnt_q, cnt_d;
  logic [7:0]       last_status_q, last_status_d;
  logic [7:0]       rem_q, rem_d;
  logic             meta_end_q, meta_end_d;
  logic             halted_q, halted_d;
  logic [6:0]       groups_q [GrpDepth];
  logic             shift_en;

  phase_e           ph;
  logic [DCntW-1:0] cnt;
  logic [7:0]       ls;
  logic [7:0]       rem;
  logic             meta_end;
  logic             halt;
  logic [7:0]       b;
  logic             done;
  logic             meta_done;
  status_e          code;
  result_t          res;

  always_comb begin
    b        = beat_i.data;
    ph       = beat_i.start ? PhDelta : phase_q;
    cnt      = beat_i.start ? '0 : cnt_q;
    ls       = beat_i.start ? 8'h00 : last_status_q;
    rem      = beat_i.start ? 8'h00 : rem_q;
    meta_end = beat_i.start ? 1'b0 : meta_end_q;
    halt     = beat_i.start ? 1'b0 : halted_q;

    phase_d       = ph;
    cnt_d         = cnt;
    last_status_d = ls;
    rem_d         = rem;
    meta_end_d    = meta_end;
    halted_d      = halt;
    shift_en      = 1'b0;

    res       = '0;
    code      = StOk;
    done      = 1'b0;
    meta_done = 1'b0;

    if (!halt) begin
      case (ph)
        PhDelta: begin
          if (b[7]) begin
            res.data[0] = {cnt != '0, b[6:0]};
            for (int j = 1; j < MaxDeltaBytes; j++) begin
              res.data[j] = {DCntW'(j) < cnt, groups_q[j-1]};
            end
            res.num = NumW'(cnt) + NumW'(1);
            cnt_d   = '0;
            phase_d = PhEvent;
          end else if (cnt >= DCntW'(MaxDeltaBytes - 1)) begin
            code = StDeltaLong;
          end else begin
            shift_en = 1'b1;
            cnt_d    = cnt + DCntW'(1);
          end
        end
        PhEvent: begin
          if (b == MetaByte) begin
            res.data[0] = b;
            res.num     = NumW'(1);
            phase_d     = PhMetaType;
          end else if (!b[7]) begin
            code = StBadStatus;
          end else if (b[7:4] == HiSystem) begin
            code = StSystem;
          end else begin
            if (b != ls) begin
              res.data[0] = b;
              res.num     = NumW'(1);
            end
            last_status_d = b;
            rem_d = (b[7:4] == HiProgChange || b[7:4] == HiChanPress) ? 8'd1 : 8'd2;
            phase_d = PhChan;
          end
        end
        PhMetaType: begin
          res.data[0] = b;
          res.num     = NumW'(1);
          meta_end_d  = (b == EndOfTrack);
          phase_d     = PhMetaLen;
        end
        PhMetaLen: begin
          res.data[0] = b;
          res.num     = NumW'(1);
          rem_d       = b;
          if (b == 8'h00) begin
            done      = 1'b1;
            meta_done = 1'b1;
          end else begin
            phase_d = PhMetaBody;
          end
        end
        PhMetaBody, PhChan: begin
          res.data[0] = b;
          res.num     = NumW'(1);
          if (rem <= 8'd1) begin
            rem_d     = 8'h00;
            done      = 1'b1;
            meta_done = (ph == PhMetaBody);
          end else begin
            rem_d = rem - 8'd1;
          end
        end
        default: begin
          phase_d = PhDelta;
          cnt_d   = '0;
        end
      endcase

      if (done) begin
        phase_d = PhDelta;
        if (meta_done && meta_end) begin
          code     = StEnd;
          halted_d = 1'b1;
        end
        meta_end_d = 1'b0;
      end
      if (beat_i.last) begin
        if (!done && code == StOk) begin
          code = StTrunc;
        end
        halted_d = 1'b1;
      end
      if (code inside {StBadStatus, StDeltaLong, StSystem, StTrunc}) begin
        halted_d = 1'b1;
        res.num  = NumW'(1);
        res.data = '0;
      end
    end
    res.code = code;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhDelta;
      cnt_q         <= '0;
      last_status_q <= 8'h00;
      rem_q         <= 8'h00;
      meta_end_q    <= 1'b0;
      halted_q      <= 1'b0;
    end else if (take_i) begin
      phase_q       <= phase_d;
      cnt_q         <= cnt_d;
      last_status_q <= last_status_d;
      rem_q         <= rem_d;
      meta_end_q    <= meta_end_d;
      halted_q      <= halted_d;
    end
  end

  // newest group sits at the head, so it leaves first
  always_ff @(posedge clk_i) begin
    if (take_i && shift_en) begin
      groups_q[0] <= b[6:0];
      for (int k = 1; k < GrpDepth; k++) begin
        groups_q[k] <= groups_q[k-1];
      end
    end
  end

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && halted_q && !beat_i.start |-> res_o.num == '0)
    else $error("halted parser produced results");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && res_o.code != StOk && res_o.code != StEnd
      |-> res_o.num == NumW'(1) && res_o.data[0] == 8'h00)
    else $error("error result is not a single zero beat");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DCntW'(MaxDeltaBytes - 1))
    else $error("delta count out of range");

endmodule

[src/hmtc_burst.sv]
module hmtc_burst (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hmtc_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  output logic [2:0]        status_o
);
  import hmtc_pkg::*;

  logic [NumW-1:0] cnt_q;
  logic [7:0]      data_q [MaxDeltaBytes];
  status_e         code_q;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = (cnt_q == '0) || (cnt_q == NumW'(1) && out_ready_i);
  assign out_byte_o  = data_q[0];
  assign out_last_o  = (cnt_q == NumW'(1));
  assign status_o    = out_last_o ? code_q : StOk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= res_i.num;
    end else if (pop) begin
      cnt_q <= cnt_q - NumW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < MaxDeltaBytes; k++) begin
        data_q[k] <= res_i.data[k];
      end
      code_q <= res_i.code;
    end else if (pop) begin
      for (int k = 0; k < MaxDeltaBytes - 1; k++) begin
        data_q[k] <= data_q[k+1];
      end
    end
  end

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> out_last_o)
    else $error("status on a non-final beat");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NumW'(MaxDeltaBytes))
    else $error("burst count overflow");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && res_i.num != '0 |-> cnt_q == '0 || (cnt_q == NumW'(1) && pop))
    else $error("burst loaded over pending beats");

endmodule

[src/hmp_to_midi_track_converter.sv]
// hmp track to midi track byte converter
// input channel: one hmp track byte per beat on in_byte_i, with track_start_i
//   on the first byte of a track and track_last_i on its final byte
// output channel: midi track bytes on out_byte_o; out_last_o marks the last
//   beat caused by one input byte, status_o carries a code on that beat only
// path: each byte enters the input register, then its beats the burst register
// throughput: one input byte per cycle while each byte yields at most one
//   beat and the receiver is ready; a delta terminator yields up to four
//   beats, one per ready cycle from the burst register, while input waits
// bytes with no beat (delta groups, halted stream) go one per cycle once none are pending
// reset: parser returns to expecting a delta, running status cleared, no
//   beats pending; track_start_i clears the parser the same way for a new track
// receiver stall: the pending beat holds, one more input byte is taken into
//   the input register, then in_ready_o drops
module hmp_to_midi_track_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       track_start_i,
  input  logic       track_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic [2:0] status_o
);
  import hmtc_pkg::*;

  logic    s1_valid_q;
  beat_t   s1_beat_q;
  logic    free;
  logic    advance;
  result_t res;

  assign advance    = s1_valid_q && free;
  assign in_ready_o = !s1_valid_q || free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_beat_q <= '{data: in_byte_i, start: track_start_i, last: track_last_i};
    end
  end

  hmtc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (advance),
    .beat_i (s1_beat_q),
    .res_o  (res)
  );

  hmtc_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .status_o    (status_o)
  );

endmodule

[dv/hmp_to_midi_track_converter_checker.sv]
`timescale 1ns / 1ps
module hmp_to_midi_track_converter_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       track_start_i,
  input  logic       track_last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i,
  input  logic [2:0] status_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         hmp_bytes_o,
  output int         midi_beats_o,
  output int         end_stops_o,
  output int         error_stops_o
);
  import hmtc_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    status_e    code;
  } midi_beat_t;

  midi_beat_t  midi_due_q[$];

  phase_e      ph;
  logic [6:0]  grp [MaxDeltaBytes];
  int unsigned dcnt;
  logic [7:0]  run_status;
  logic [7:0]  remain;
  logic        meta_end;
  logic        halted;

  int mismatches;
  int due_count;
  int hmp_bytes;
  int midi_beats;
  int end_stops;
  int error_stops;

  assign fail_count_o  = mismatches;
  assign pending_o     = due_count;
  assign hmp_bytes_o   = hmp_bytes;
  assign midi_beats_o  = midi_beats;
  assign end_stops_o   = end_stops;
  assign error_stops_o = error_stops;

  task automatic clear_parser();
    ph = PhDelta;
    foreach (grp[i]) grp[i] = '0;
    dcnt = 0;
    run_status = '0;
    remain = '0;
    meta_end = 1'b0;
    halted = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 20) begin
      $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic convert_byte(input logic [7:0] b, input logic st, input logic lst);
    logic [7:0] burst [$];
    status_e    code;
    bit         done;
    bit         meta_done;
    int         i;
    code = StOk;
    done = 1'b0;
    meta_done = 1'b0;
    if (st) clear_parser();
    if (halted) return;

    case (ph)
      PhDelta: begin
        if (b[7]) begin
          // groups arrive least significant first, midi wants them reversed
          burst.push_back({dcnt != 0, b[6:0]});
          for (i = dcnt; i > 0; i--) burst.push_back({i > 1, grp[i-1]});
          dcnt = 0;
          ph = PhEvent;
        end else if (dcnt >= MaxDeltaBytes - 1) begin
          code = StDeltaLong;
        end else begin
          grp[dcnt] = b[6:0];
          dcnt++;
        end
      end
      PhEvent: begin
        if (b == MetaByte) begin
          burst.push_back(b);
          ph = PhMetaType;
        end else if (!b[7]) begin
          code = StBadStatus;
        end else if (b[7:4] == HiSystem) begin
          code = StSystem;
        end else begin
          if (b != run_status) burst.push_back(b);
          run_status = b;
          remain = (b[7:4] == HiProgChange || b[7:4] == HiChanPress) ? 8'd1 : 8'd2;
          ph = PhChan;
        end
      end
      PhMetaType: begin
        burst.push_back(b);
        meta_end = (b == EndOfTrack);
        ph = PhMetaLen;
      end
      PhMetaLen: begin
        burst.push_back(b);
        remain = b;
        if (b == 8'd0) begin
          done = 1'b1;
          meta_done = 1'b1;
        end else begin
          ph = PhMetaBody;
        end
      end
      PhMetaBody: begin
        burst.push_back(b);
        if (remain <= 8'd1) begin
          remain = '0;
          done = 1'b1;
          meta_done = 1'b1;
        end else begin
          remain--;
        end
      end
      PhChan: begin
        burst.push_back(b);
        if (remain <= 8'd1) begin
          remain = '0;
          done = 1'b1;
        end else begin
          remain--;
        end
      end
      default: begin
        ph = PhDelta;
        dcnt = 0;
        return;
      end
    endcase

    if (done) begin
      ph = PhDelta;
      if (meta_done && meta_end) begin
        code = StEnd;
        halted = 1'b1;
      end
      meta_end = 1'b0;
    end
    if (lst) begin
      if (!done && code == StOk) code = StTrunc;
      halted = 1'b1;
    end

    if (code >= StBadStatus) begin
      // any bytes already produced for this beat are dropped
      halted = 1'b1;
      error_stops++;
      midi_due_q.push_back('{data: 8'h00, last: 1'b1, code: code});
    end else begin
      if (code == StEnd) end_stops++;
      for (i = 0; i < burst.size(); i++) begin
        midi_due_q.push_back('{data: burst[i], last: i == burst.size() - 1,
                               code: (i == burst.size() - 1) ? code : StOk});
      end
    end
  endtask

  task automatic check_beat();
    midi_beat_t want;
    midi_beats++;
    if (midi_due_q.size() == 0) begin
      report_mismatch("beat with nothing due, out_byte", out_byte_i, 0);
      return;
    end
    want = midi_due_q.pop_front();
    if (out_byte_i !== want.data) report_mismatch("out_byte", out_byte_i, want.data);
    if (out_last_i !== want.last) report_mismatch("out_last", out_last_i, want.last);
    if (status_i !== want.code) report_mismatch("status", status_i, want.code);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      midi_due_q.delete();
      due_count = 0;
    end else begin
      // a beat out can never stem from the byte taken at the same edge
      if (out_valid_i && out_ready_i) check_beat();
      if (in_valid_i && in_ready_i) begin
        hmp_bytes++;
        convert_byte(in_byte_i, track_start_i, track_last_i);
      end
      due_count = midi_due_q.size();
    end
  end

endmodule

[dv/hmp_to_midi_track_converter_tb.sv]
`timescale 1ns / 1ps
module hmp_to_midi_track_converter_tb;
  import hmtc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseBytes = 50;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = '0;
  logic       in_start = 1'b0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic [2:0] status;

  int fails;
  int pending;
  int hmp_bytes;
  int midi_beats;
  int end_stops;
  int error_stops;

  int     stall_pct = 0;
  int     cycles = 0;
  int     items_made;
  logic   next_start;
  logic [7:0] chan_status = '0;
  beat_t  hmp_q[$];

  always #2 clk = ~clk;

  hmp_to_midi_track_converter dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_byte_i    (in_byte),
    .track_start_i(in_start),
    .track_last_i (in_last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte),
    .out_last_o   (out_last),
    .status_o     (status)
  );

  hmp_to_midi_track_converter_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_byte_i    (in_byte),
    .track_start_i(in_start),
    .track_last_i (in_last),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_i   (out_byte),
    .out_last_i   (out_last),
    .status_i     (status),
    .fail_count_o (fails),
    .pending_o    (pending),
    .hmp_bytes_o  (hmp_bytes),
    .midi_beats_o (midi_beats),
    .end_stops_o  (end_stops),
    .error_stops_o(error_stops)
  );

  always @(negedge clk) out_ready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles with %0d beats still due", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  task automatic add(input logic [7:0] b, input bit counted = 1'b1);
    hmp_q.push_back('{data: b, start: next_start, last: 1'b0});
    next_start = 1'b0;
    if (counted) items_made++;
  endtask

  task automatic mark_last();
    hmp_q[hmp_q.size() - 1].last = 1'b1;
  endtask

  task automatic add_delta(input int n);
    repeat (n - 1) add(8'($urandom_range(0, 127)));
    add(8'($urandom_range(128, 255)));
  endtask

  task automatic add_chan();
    int ndata;
    if (chan_status == 8'h00 || $urandom_range(2) == 0) begin
      chan_status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
    end
    add(chan_status);
    ndata = (chan_status[7:4] == HiProgChange || chan_status[7:4] == HiChanPress) ? 1 : 2;
    repeat (ndata) begin
      if ($urandom_range(99) < 10) add(8'($urandom));
      else add(8'($urandom_range(0, 127)));
    end
  endtask

  task automatic add_meta(input logic [7:0] kind, input logic [7:0] len);
    add(MetaByte);
    add(kind);
    add(len);
    repeat (len) add(8'($urandom));
  endtask

  function automatic logic [7:0] meta_len();
    int r;
    r = $urandom_range(99);
    if (r < 2) return 8'hFF;
    if (r < 5) return 8'($urandom_range(6, 254));
    return 8'($urandom_range(0, 5));
  endfunction

  function automatic logic [7:0] plain_meta_kind();
    logic [7:0] k;
    k = 8'($urandom);
    return (k == EndOfTrack) ? 8'h01 : k;
  endfunction

  task automatic load_directed();
    next_start = 1'b1;
    add(8'h80); add(8'h90); add(8'h3C); add(8'h7F);
    // longest delta, then running status drops the repeated status
    add(8'h00); add(8'h7F); add(8'h7F); add(8'hFF); add(8'h90); add(8'h40); add(8'h00);
    add(8'h85); add(8'hC0); add(8'h05);
    add(8'h80); add(8'hFF); add(8'h01); add(8'h00);
    add(8'h80); add(8'hFF); add(8'h2F); add(8'h00);
    add(8'h11, 1'b0);
    next_start = 1'b1;
    add(8'h80); add(8'h40);
    next_start = 1'b1;
    add(8'h80); add(8'hF0);
    next_start = 1'b1;
    add(8'h00); add(8'h00); add(8'h00); add(8'h00);
    next_start = 1'b1;
    add(8'h80); add(8'hE3); add(8'h00); mark_last();
  endtask

  task automatic gen_track();
    int kind;
    next_start = 1'b1;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 8)) add(8'($urandom));
      if ($urandom_range(1) == 1) mark_last();
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      add_delta($urandom_range(1, MaxDeltaBytes));
      if ($urandom_range(99) < 70) add_chan();
      else add_meta(plain_meta_kind(), meta_len());
    end
    kind = $urandom_range(99);
    if (kind < 45) begin
      add_delta($urandom_range(1, MaxDeltaBytes));
      add_meta(EndOfTrack, ($urandom_range(3) == 0) ? 8'($urandom_range(1, 3)) : 8'h00);
      if ($urandom_range(3) == 0) mark_last();
    end else if (kind < 60) begin
      mark_last();
    end else if (kind < 65) begin
      // left open, the next track start must clear it
    end else if (kind < 72) begin
      add_delta($urandom_range(1, MaxDeltaBytes));
      add(8'($urandom_range(0, 127)));
    end else if (kind < 79) begin
      add_delta($urandom_range(1, MaxDeltaBytes));
      add(8'($urandom_range(8'hF0, 8'hFE)));
    end else if (kind < 86) begin
      repeat (MaxDeltaBytes) add(8'($urandom_range(0, 127)));
    end else begin
      case ($urandom_range(2))
        0: repeat ($urandom_range(1, MaxDeltaBytes - 1)) add(8'($urandom_range(0, 127)));
        1: begin
          add_delta($urandom_range(1, MaxDeltaBytes));
          add(8'($urandom_range(8'h80, 8'hEF)));
        end
        default: begin
          add_delta(1);
          add(MetaByte);
          add(plain_meta_kind());
          add(8'($urandom_range(2, 9)));
          add(8'($urandom));
        end
      endcase
      mark_last();
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) add(8'($urandom), 1'b0);
  endtask

  task automatic send_beats(input int idle_pct, input int recv_stall_pct);
    stall_pct = recv_stall_pct;
    foreach (hmp_q[i]) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
      in_valid = 1'b1;
      in_byte  = hmp_q[i].data;
      in_start = hmp_q[i].start;
      in_last  = hmp_q[i].last;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
    end
    in_valid = 1'b0;
    hmp_q.delete();
  endtask

  task automatic random_phase(input int idle_pct, input int recv_stall_pct);
    items_made = 0;
    while (items_made < PhaseBytes) gen_track();
    send_beats(idle_pct, recv_stall_pct);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    load_directed();
    send_beats(0, 0);
    random_phase(0, 0);
    random_phase(87, 0);
    random_phase(0, 87);
    random_phase(12, 12);

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("fed %0d hmp track bytes, checked %0d midi beats out", hmp_bytes, midi_beats);
    $display("%0d tracks closed by end meta, %0d stopped on a parse error",
             end_stops, error_stops);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
